// ===== sv/mi3_pkg.sv =====
package mi3_pkg;

   localparam int DIM   = 3;
   localparam int LANES = DIM * DIM;

   typedef struct packed {
      logic valid;
      logic singular;
   } mi3_tag_type;

endpackage

// ===== sv/mi3_fifo.sv =====
module mi3_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH)) else $error("queue count out of range");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers apart while empty");

endmodule

// ===== sv/mi3_front.sv =====
module mi3_front #(
   parameter int W = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_push,
   output logic                 in_full,
   input  logic [9*W-1:0]       in_a,
   output logic                 out_push,
   input  logic                 out_full,
   output mi3_pkg::mi3_tag_type out_tag,
   output logic [3*W+2:0]       out_det,
   output logic [9*(2*W+1)-1:0] out_cof,
   output logic [9*W-1:0]       out_a
);

   localparam int CW = 2 * W + 1;
   localparam int DW = 3 * W + 3;
   localparam int LB = W + 1;
   localparam int N  = mi3_pkg::DIM;
   localparam int L  = mi3_pkg::LANES;

   logic [4:0]          v_ff;
   logic                en;
   logic signed [W-1:0]    a_ff   [0:4][0:L-1];
   logic signed [2*W-1:0]  pp_ff  [0:L-1];
   logic signed [2*W-1:0]  pm_ff  [0:L-1];
   logic signed [2*W-1:0]  pp_in  [0:L-1];
   logic signed [2*W-1:0]  pm_in  [0:L-1];
   logic signed [CW-1:0]   cof_ff [2:4][0:L-1];
   logic signed [CW-1:0]   cof_in [0:L-1];
   logic signed [2*W+1:0]  dl_ff  [0:N-1];
   logic signed [2*W+1:0]  dl_in  [0:N-1];
   logic signed [2*W-1:0]  dh_ff  [0:N-1];
   logic signed [2*W-1:0]  dh_in  [0:N-1];
   logic signed [DW-1:0]   det_ff, det_in;

   assign en       = !v_ff[4] || !out_full;
   assign in_full  = !en;
   assign out_push = v_ff[4] && !out_full;

   always_comb begin
      int r0, r1, c0, c1;
      for (int r = 0; r < N; r++) begin
         for (int c = 0; c < N; c++) begin
            r0 = (r == 0) ? 1 : 0;
            r1 = (r == 2) ? 1 : 2;
            c0 = (c == 0) ? 1 : 0;
            c1 = (c == 2) ? 1 : 2;
            pp_in[r*N+c] = (2*W)'(a_ff[0][r0*N+c0]) * (2*W)'(a_ff[0][r1*N+c1]);
            pm_in[r*N+c] = (2*W)'(a_ff[0][r0*N+c1]) * (2*W)'(a_ff[0][r1*N+c0]);
         end
      end
      for (int k = 0; k < L; k++) begin
         if (((k / N) + (k % N)) % 2 == 1) begin
            cof_in[k] = CW'(pm_ff[k]) - CW'(pp_ff[k]);
         end else begin
            cof_in[k] = CW'(pp_ff[k]) - CW'(pm_ff[k]);
         end
      end
      for (int j = 0; j < N; j++) begin
         dl_in[j] = (2*W+2)'(a_ff[2][j]) *
                    (2*W+2)'($signed({1'b0, cof_ff[2][j][LB-1:0]}));
         dh_in[j] = (2*W)'(a_ff[2][j]) * (2*W)'($signed(cof_ff[2][j][CW-1:LB]));
      end
      det_in = '0;
      for (int j = 0; j < N; j++) begin
         det_in = det_in + (DW'(dh_ff[j]) <<< LB) + DW'(dl_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[3:0], in_push};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < L; k++) begin
            a_ff[0][k] <= in_a[k*W +: W];
            for (int s = 1; s < 5; s++) begin
               a_ff[s][k] <= a_ff[s-1][k];
            end
            pp_ff[k]     <= pp_in[k];
            pm_ff[k]     <= pm_in[k];
            cof_ff[2][k] <= cof_in[k];
            cof_ff[3][k] <= cof_ff[2][k];
            cof_ff[4][k] <= cof_ff[3][k];
         end
         for (int j = 0; j < N; j++) begin
            dl_ff[j] <= dl_in[j];
            dh_ff[j] <= dh_in[j];
         end
         det_ff <= det_in;
      end
   end

   always_comb begin
      out_tag.valid    = v_ff[4];
      out_tag.singular = (det_ff == '0);
      out_det          = det_ff;
      for (int k = 0; k < L; k++) begin
         out_cof[k*CW +: CW] = cof_ff[4][(k % N) * N + k / N];
         out_a[k*W +: W]     = a_ff[4][k];
      end
   end

endmodule

// ===== sv/mi3_back.sv =====
module mi3_back #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_empty,
   output logic                 in_pop,
   input  mi3_pkg::mi3_tag_type in_tag,
   input  logic [3*W+2:0]       in_det,
   input  logic [9*(2*W+1)-1:0] in_cof,
   input  logic [9*W-1:0]       in_a,
   output logic                 out_push,
   input  logic                 out_full,
   output logic [9*W-1:0]       out_data,
   output logic                 out_singular,
   output logic                 out_saturated
);

   localparam int CW = 2 * W + 1;
   localparam int DW = 3 * W + 3;
   localparam int NW = 2 * W + 2 * F;
   localparam int HW = NW - W;
   localparam int XW = (HW > DW) ? HW : DW;
   localparam int L  = mi3_pkg::LANES;
   localparam int LAST = W + 1;

   logic [LAST:0]    v_ff;
   logic             en;
   logic [DW-1:0]    dmag_ff [0:W];
   logic             sing_ff [0:W];
   logic [W-1:0]     a_ff    [0:W][0:L-1];
   logic             neg_ff  [0:W][0:L-1];
   logic             ovf_ff  [0:W][0:L-1];
   logic [DW-1:0]    rem_ff  [0:W][0:L-1];
   logic [W-1:0]     low_ff  [0:W][0:L-1];
   logic [W-1:0]     q_ff    [0:W][0:L-1];
   logic [DW-1:0]    dmag_in;
   logic             neg_in  [0:L-1];
   logic             ovf_in  [0:L-1];
   logic [DW-1:0]    rem_in  [0:W][0:L-1];
   logic [W-1:0]     low_in  [0:L-1];
   logic             bit_in  [1:W][0:L-1];
   logic [W-1:0]     res_in  [0:L-1];
   logic             sat_lane[0:L-1];
   logic [W-1:0]     res_ff  [0:L-1];
   logic             sat_ff, singo_ff;

   assign en       = !v_ff[LAST] || !out_full;
   assign in_pop   = en && !in_empty;
   assign out_push = v_ff[LAST] && !out_full;

   always_comb begin
      logic [CW-1:0] cof, cmag;
      logic [NW-1:0] num;
      logic [HW-1:0] hi;
      logic [DW:0]   t;
      logic          dneg;
      dneg    = in_det[DW-1];
      dmag_in = dneg ? (~in_det + 1'b1) : in_det;
      for (int k = 0; k < L; k++) begin
         cof       = in_cof[k*CW +: CW];
         cmag      = cof[CW-1] ? (~cof + 1'b1) : cof;
         num       = {cmag[2*W-1:0], {(2*F){1'b0}}};
         hi        = num[NW-1:W];
         low_in[k] = num[W-1:0];
         neg_in[k] = cof[CW-1] ^ dneg;
         ovf_in[k] = XW'(hi) >= XW'(dmag_in);
         rem_in[0][k] = ovf_in[k] ? '0 : DW'(hi);
      end
      for (int s = 1; s <= W; s++) begin
         for (int k = 0; k < L; k++) begin
            t = {rem_ff[s-1][k], low_ff[s-1][k][W-1]};
            bit_in[s][k] = t >= {1'b0, dmag_ff[s-1]};
            rem_in[s][k] = bit_in[s][k] ? DW'(t - {1'b0, dmag_ff[s-1]}) : DW'(t);
         end
      end
      for (int k = 0; k < L; k++) begin
         if (neg_ff[W][k]) begin
            sat_lane[k] = ovf_ff[W][k] || (q_ff[W][k] > {1'b1, {(W-1){1'b0}}});
            res_in[k]   = sat_lane[k] ? {1'b1, {(W-1){1'b0}}} : (~q_ff[W][k] + 1'b1);
         end else begin
            sat_lane[k] = ovf_ff[W][k] || q_ff[W][k][W-1];
            res_in[k]   = sat_lane[k] ? {1'b0, {(W-1){1'b1}}} : q_ff[W][k];
         end
         if (sing_ff[W]) begin
            res_in[k]   = a_ff[W][k];
            sat_lane[k] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[LAST-1:0], in_pop && in_tag.valid};
      end
   end

   always_ff @(posedge clock) begin
      logic sat;
      sat = 1'b0;
      if (en) begin
         dmag_ff[0] <= dmag_in;
         sing_ff[0] <= in_tag.singular;
         for (int k = 0; k < L; k++) begin
            a_ff[0][k]   <= in_a[k*W +: W];
            neg_ff[0][k] <= neg_in[k];
            ovf_ff[0][k] <= ovf_in[k];
            rem_ff[0][k] <= rem_in[0][k];
            low_ff[0][k] <= low_in[k];
            q_ff[0][k]   <= '0;
         end
         for (int s = 1; s <= W; s++) begin
            dmag_ff[s] <= dmag_ff[s-1];
            sing_ff[s] <= sing_ff[s-1];
            for (int k = 0; k < L; k++) begin
               a_ff[s][k]   <= a_ff[s-1][k];
               neg_ff[s][k] <= neg_ff[s-1][k];
               ovf_ff[s][k] <= ovf_ff[s-1][k];
               rem_ff[s][k] <= rem_in[s][k];
               low_ff[s][k] <= {low_ff[s-1][k][W-2:0], 1'b0};
               q_ff[s][k]   <= {q_ff[s-1][k][W-2:0], bit_in[s][k]};
            end
         end
         for (int k = 0; k < L; k++) begin
            res_ff[k] <= res_in[k];
            sat = sat | sat_lane[k];
         end
         sat_ff   <= sat;
         singo_ff <= sing_ff[W];
      end
   end

   always_comb begin
      for (int k = 0; k < L; k++) begin
         out_data[k*W +: W] = res_ff[k];
      end
      out_singular  = singo_ff;
      out_saturated = sat_ff;
   end

endmodule

// ===== sv/matrix_inverse_3x3_unit.sv =====
// channel   direction  handshake          payload
// req       in         push / full        req_in_r0c0 .. req_in_r2c2
// rsp       out        empty / pop        rsp_out_r0c0 .. rsp_out_r2c2, rsp_singular,
//                                         rsp_saturated
//
// One matrix per cycle sustained while the response queue keeps being popped; a matrix
// passes through the front pipeline, the middle queue, the back pipeline and the response queue.
// The back pipeline computes one quotient bit per stage, in ELEMENT_WIDTH divider stages.
// Synchronous reset clears the valid bits and queue pointers; payload is not reset.
// Each half freezes as a whole when its last stage cannot hand off; the queue
// between them absorbs the difference.
module matrix_inverse_3x3_unit #(
   parameter int ELEMENT_WIDTH = 32,
   parameter int FRAC_BITS     = 16,
   parameter int QUEUE_DEPTH   = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  logic signed [ELEMENT_WIDTH-1:0] req_in_r0c0,
   input  logic signed [ELEMENT_WIDTH-1:0] req_in_r0c1,
   input  logic signed [ELEMENT_WIDTH-1:0] req_in_r0c2,
   input  logic signed [ELEMENT_WIDTH-1:0] req_in_r1c0,
   input  logic signed [ELEMENT_WIDTH-1:0] req_in_r1c1,
   input  logic signed [ELEMENT_WIDTH-1:0] req_in_r1c2,
   input  logic signed [ELEMENT_WIDTH-1:0] req_in_r2c0,
   input  logic signed [ELEMENT_WIDTH-1:0] req_in_r2c1,
   input  logic signed [ELEMENT_WIDTH-1:0] req_in_r2c2,
   output logic                            empty,
   input  logic                            pop,
   output logic signed [ELEMENT_WIDTH-1:0] rsp_out_r0c0,
   output logic signed [ELEMENT_WIDTH-1:0] rsp_out_r0c1,
   output logic signed [ELEMENT_WIDTH-1:0] rsp_out_r0c2,
   output logic signed [ELEMENT_WIDTH-1:0] rsp_out_r1c0,
   output logic signed [ELEMENT_WIDTH-1:0] rsp_out_r1c1,
   output logic signed [ELEMENT_WIDTH-1:0] rsp_out_r1c2,
   output logic signed [ELEMENT_WIDTH-1:0] rsp_out_r2c0,
   output logic signed [ELEMENT_WIDTH-1:0] rsp_out_r2c1,
   output logic signed [ELEMENT_WIDTH-1:0] rsp_out_r2c2,
   output logic                            rsp_singular,
   output logic                            rsp_saturated
);

   localparam int W  = ELEMENT_WIDTH;
   localparam int CW = 2 * W + 1;
   localparam int DW = 3 * W + 3;
   localparam int MW = 2 + DW + 9 * CW + 9 * W;
   localparam int OW = 9 * W + 2;

   logic                 f_push, m_full, m_empty, b_pop, b_push, o_full;
   mi3_pkg::mi3_tag_type f_tag, m_tag;
   logic [DW-1:0]        f_det, m_det;
   logic [9*CW-1:0]      f_cof, m_cof;
   logic [9*W-1:0]       f_a, m_a, b_data;
   logic                 b_sing, b_sat;
   logic [MW-1:0]        m_rdata;
   logic [OW-1:0]        o_rdata;

   mi3_front #(.W(W)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_push  (push),
      .in_full  (full),
      .in_a     ({req_in_r2c2, req_in_r2c1, req_in_r2c0,
                  req_in_r1c2, req_in_r1c1, req_in_r1c0,
                  req_in_r0c2, req_in_r0c1, req_in_r0c0}),
      .out_push (f_push),
      .out_full (m_full),
      .out_tag  (f_tag),
      .out_det  (f_det),
      .out_cof  (f_cof),
      .out_a    (f_a)
   );

   mi3_fifo #(.WIDTH(MW), .DEPTH(QUEUE_DEPTH)) u_mid_q (
      .clock (clock),
      .reset (reset),
      .push  (f_push),
      .wdata ({f_tag, f_det, f_cof, f_a}),
      .full  (m_full),
      .pop   (b_pop),
      .rdata (m_rdata),
      .empty (m_empty)
   );

   assign {m_tag, m_det, m_cof, m_a} = m_rdata;

   mi3_back #(.W(W), .F(FRAC_BITS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .in_empty      (m_empty),
      .in_pop        (b_pop),
      .in_tag        (m_tag),
      .in_det        (m_det),
      .in_cof        (m_cof),
      .in_a          (m_a),
      .out_push      (b_push),
      .out_full      (o_full),
      .out_data      (b_data),
      .out_singular  (b_sing),
      .out_saturated (b_sat)
   );

   mi3_fifo #(.WIDTH(OW), .DEPTH(QUEUE_DEPTH)) u_out_q (
      .clock (clock),
      .reset (reset),
      .push  (b_push),
      .wdata ({b_sing, b_sat, b_data}),
      .full  (o_full),
      .pop   (pop),
      .rdata (o_rdata),
      .empty (empty)
   );

   assign {rsp_singular, rsp_saturated,
           rsp_out_r2c2, rsp_out_r2c1, rsp_out_r2c0,
           rsp_out_r1c2, rsp_out_r1c1, rsp_out_r1c0,
           rsp_out_r0c2, rsp_out_r0c1, rsp_out_r0c0} = o_rdata;

endmodule
